/* rtl/core/knife_element_volume_check_defines.svh */
// assertion macros shared by the knife element volume checker
`ifndef KNIFE_ELEMENT_VOLUME_CHECK_DEFINES_SVH
`define KNIFE_ELEMENT_VOLUME_CHECK_DEFINES_SVH

// condition implies consequence in the next cycle, off during reset
`define KEVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kevc next-cycle check failed");

// consequence holds at every edge while reset is applied
`define KEVC_ASSERT_RESET(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) (!rst_n) |-> (cons)) \
        else $error("kevc reset check failed");

`endif

/* rtl/core/kevc_pkg.sv */
// shared types, constants and helpers for the knife element volume check
package kevc_pkg;

    // element shape and field widths
    localparam int NODES_PER_ELEMENT = 7;
    localparam int COORD_WIDTH       = 16;
    localparam int COORD_W           = 16;
    localparam int TAG_W             = 31;
    localparam int VOL_W             = 56;
    localparam int TOL_W             = 55;
    localparam int TOTAL_W           = 64;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 56;

    // arithmetic widths
    localparam int DIFF_W  = COORD_W + 1;
    localparam int HOLD_W  = 2 * DIFF_W;
    localparam int CROSS_W = HOLD_W + 1;
    localparam int PROD_W  = DIFF_W + CROSS_W;
    localparam int LIM_W   = VOL_W + 2;

    // node counter and store
    localparam int CNT_W     = $clog2(NODES_PER_ELEMENT);
    localparam int STORE_CNT = NODES_PER_ELEMENT - 1;

    // job queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // tetrahedra and divide by six in 14-bit digits
    localparam int TET_COUNT = 4;
    localparam int TET_W     = $clog2(TET_COUNT);
    localparam int DIGIT_W   = 14;
    localparam int DIV_STEPS = VOL_W / DIGIT_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int REM_W     = 3;
    localparam int DVAL_W    = REM_W + DIGIT_W;
    localparam int RECIP_W   = 18;
    localparam int RECIP_SH  = 20;
    localparam int RPROD_W   = DVAL_W + RECIP_W;
    localparam logic [REM_W:0] DIVISOR   = 4'd6;
    // ceil(2^20 / 6), exact quotient for any partial dividend below 2^19
    localparam logic [RECIP_W-1:0] RECIP6 = 18'd174763;
    localparam logic [VOL_W-1:0] ROUND_HALF = VOL_W'(3);

    // multiply sequence of one tetrahedron
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] M_CX_P  = 4'd0;
    localparam logic [STEP_W-1:0] M_CX_N  = 4'd1;
    localparam logic [STEP_W-1:0] M_CY_P  = 4'd2;
    localparam logic [STEP_W-1:0] M_CY_N  = 4'd3;
    localparam logic [STEP_W-1:0] M_CZ_P  = 4'd4;
    localparam logic [STEP_W-1:0] M_CZ_N  = 4'd5;
    localparam logic [STEP_W-1:0] M_DOT_X = 4'd6;
    localparam logic [STEP_W-1:0] M_DOT_Y = 4'd7;
    localparam logic [STEP_W-1:0] M_DOT_Z = 4'd8;

    // register reset value and running total saturation limits
    localparam logic signed [VOL_W-1:0] VMAX_RESET = {1'b0, {(VOL_W-1){1'b1}}};
    localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
    localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } node_t;

    typedef struct packed {
        diff_t x;
        diff_t y;
        diff_t z;
    } vec_t;

    // one queue entry: a finished element or a clear
    typedef struct packed {
        logic                               is_clear;
        logic [TAG_W-1:0]                   tag;
        node_t [NODES_PER_ELEMENT-1:0]      nodes;
    } kevc_job_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIAG = 2'd0,
        REG_VMIN = 2'd1,
        REG_VMAX = 2'd2,
        REG_TOL  = 2'd3
    } kevc_reg_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOAD,
        BK_MUL,
        BK_DRAIN,
        BK_ROUND,
        BK_DIV,
        BK_SIGN,
        BK_EMIT
    } kevc_bk_state_t;

    // keep the low COORD_WIDTH bits, sign extended
    function automatic coord_t coord_sext(input coord_t v);
        coord_t r;
        r = v;
        for (int i = COORD_WIDTH; i < COORD_W; i++)
        begin
            r[i] = v[COORD_WIDTH-1];
        end
        return r;
    endfunction

    // edge vector p - q
    function automatic vec_t node_diff(input node_t p, input node_t q);
        vec_t r;
        r.x = diff_t'({p.x[COORD_W-1], p.x}) - diff_t'({q.x[COORD_W-1], q.x});
        r.y = diff_t'({p.y[COORD_W-1], p.y}) - diff_t'({q.y[COORD_W-1], q.y});
        r.z = diff_t'({p.z[COORD_W-1], p.z}) - diff_t'({q.z[COORD_W-1], q.z});
        return r;
    endfunction

    // sign extend an edge component to the cross product width
    function automatic logic signed [CROSS_W-1:0] diff_ext(input diff_t d);
        return {{(CROSS_W-DIFF_W){d[DIFF_W-1]}}, d};
    endfunction

endpackage

/* rtl/core/kevc_node_if.sv */
// node item channel: valid, ready and one node coordinate or clear
interface kevc_node_if;
    import kevc_pkg::*;

    logic             valid;
    logic             ready;
    logic             action;
    coord_t           coord_x;
    coord_t           coord_y;
    coord_t           coord_z;
    logic [TAG_W-1:0] element_tag;

    modport source
    (
        output valid, action, coord_x, coord_y, coord_z, element_tag,
        input  ready
    );

    modport sink
    (
        input  valid, action, coord_x, coord_y, coord_z, element_tag,
        output ready
    );
endinterface

/* rtl/core/kevc_result_if.sv */
// result channel: valid, ready and one element volume report
interface kevc_result_if;
    import kevc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VOL_W-1:0]   element_volume;
    logic                      out_of_range;
    logic signed [TOTAL_W-1:0] running_total;
    logic [TAG_W-1:0]          element_id_out;

    modport source
    (
        output valid, element_volume, out_of_range, running_total, element_id_out,
        input  ready
    );

    modport sink
    (
        input  valid, element_volume, out_of_range, running_total, element_id_out,
        output ready
    );
endinterface

/* rtl/core/kevc_queue.sv */
// short job queue between the node front end and the volume back end
module kevc_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  kevc_pkg::kevc_job_t push_job,
    output logic               full,
    input  logic               pop,
    output kevc_pkg::kevc_job_t head,
    output logic               empty
);
    import kevc_pkg::*;

    kevc_job_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    // status
    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                if (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                    wr_ptr_reg <= '0;
                else
                    wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                if (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                    rd_ptr_reg <= '0;
                else
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end
endmodule

/* rtl/core/kevc_front.sv */
// front end: takes node transfers, collects an element, queues jobs
module kevc_front
(
    input  logic                clk,
    input  logic                rst_n,
    kevc_node_if.sink           node_in,
    input  logic                diag_en,
    input  logic                full,
    output logic                push,
    output kevc_pkg::kevc_job_t push_job
);
    import kevc_pkg::*;

    node_t              store_reg [STORE_CNT];
    logic [CNT_W-1:0]   count_reg;
    logic               accept;
    logic               last;
    node_t              node_now;

    // handshake and element position
    assign node_in.ready = !full;
    assign accept        = node_in.valid && node_in.ready;
    assign last          = (count_reg == CNT_W'(NODES_PER_ELEMENT - 1));

    assign node_now.x = coord_sext(node_in.coord_x);
    assign node_now.y = coord_sext(node_in.coord_y);
    assign node_now.z = coord_sext(node_in.coord_z);

    // clears always queue to keep order with the total; elements only with diagnostics
    assign push = accept && (node_in.action || (last && diag_en));

    // job built from the held nodes plus the incoming last node
    always_comb
    begin
        push_job.is_clear = node_in.action;
        push_job.tag      = node_in.element_tag;
        for (int i = 0; i < STORE_CNT; i++)
        begin
            push_job.nodes[i] = store_reg[i];
        end
        push_job.nodes[STORE_CNT] = node_now;
    end

    // node store
    always_ff @(posedge clk)
    begin
        if (accept && !node_in.action && !last)
        begin
            store_reg[count_reg] <= node_now;
        end
    end

    // node count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            if (node_in.action || last)
                count_reg <= '0;
            else
                count_reg <= count_reg + 1'b1;
        end
    end
endmodule

/* rtl/core/kevc_back.sv */
// back end: triple products on one shared multiplier, divide by six, total and range check
module kevc_back
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  kevc_pkg::kevc_job_t                head,
    input  logic                               empty,
    output logic                               pop,
    input  logic signed [kevc_pkg::VOL_W-1:0]  vmin,
    input  logic signed [kevc_pkg::VOL_W-1:0]  vmax,
    input  logic [kevc_pkg::TOL_W-1:0]         tol,
    kevc_result_if.source                      result_out
);
    import kevc_pkg::*;

    kevc_bk_state_t state_reg, state_next;

    logic [TET_W-1:0]          tet_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [DCNT_W-1:0]         div_cnt_reg;
    logic                      prod_vld_reg;
    logic [STEP_W-1:0]         prod_idx_reg;
    logic signed [TOTAL_W-1:0] total_reg;
    logic                      out_valid_reg;

    vec_t                      u_reg, v_reg, w_reg;
    logic signed [HOLD_W-1:0]  hold_reg;
    logic signed [CROSS_W-1:0] cx_reg, cy_reg, cz_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [VOL_W-1:0]   jsum_reg;
    logic                      neg_reg;
    logic [VOL_W-1:0]          div_reg;
    logic [REM_W-1:0]          rem_reg;
    logic signed [VOL_W-1:0]   vol_reg;
    logic signed [LIM_W-1:0]   hi_lim_reg, lo_lim_reg;

    logic signed [VOL_W-1:0]   out_vol_reg;
    logic                      out_bad_reg;
    logic signed [TOTAL_W-1:0] out_total_reg;
    logic [TAG_W-1:0]          out_id_reg;

    logic                      start_job;
    logic                      clear_job;
    logic                      emit;
    node_t                     pa, pb, pc, pd;
    logic signed [DIFF_W-1:0]  mul_a;
    logic signed [CROSS_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [DVAL_W-1:0]         dval;
    logic [RPROD_W-1:0]        rprod;
    logic [DIGIT_W-1:0]        q_dig;
    logic [DVAL_W-1:0]         q_six;
    logic [DVAL_W-1:0]         rem_full;
    logic [VOL_W-1:0]          jsum_mag;
    logic signed [TOTAL_W:0]   sum_ext;
    logic signed [TOTAL_W-1:0] total_new;
    logic signed [LIM_W-1:0]   vol_ext;
    logic                      bad;
    logic                      out_xfer;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and queue pop
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        start_job  = 1'b0;
        clear_job  = 1'b0;
        emit       = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    if (head.is_clear)
                    begin
                        clear_job = 1'b1;
                        pop       = 1'b1;
                    end
                    else
                    begin
                        start_job  = 1'b1;
                        state_next = BK_LOAD;
                    end
                end
            end
            BK_LOAD:
            begin
                state_next = BK_MUL;
            end
            BK_MUL:
            begin
                if (step_reg == M_DOT_Z)
                begin
                    if (tet_reg == TET_W'(TET_COUNT - 1))
                        state_next = BK_DRAIN;
                    else
                        state_next = BK_LOAD;
                end
            end
            BK_DRAIN:
            begin
                state_next = BK_ROUND;
            end
            BK_ROUND:
            begin
                state_next = BK_DIV;
            end
            BK_DIV:
            begin
                if (div_cnt_reg == DCNT_W'(DIV_STEPS - 1))
                    state_next = BK_SIGN;
            end
            BK_SIGN:
            begin
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (!out_valid_reg)
                begin
                    emit       = 1'b1;
                    pop        = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // vertices of the current tetrahedron
    always_comb
    begin
        case (tet_reg)
            2'd0:
            begin
                pa = head.nodes[0]; pb = head.nodes[1]; pc = head.nodes[3]; pd = head.nodes[4];
            end
            2'd1:
            begin
                pa = head.nodes[1]; pb = head.nodes[5]; pc = head.nodes[3]; pd = head.nodes[4];
            end
            2'd2:
            begin
                pa = head.nodes[1]; pb = head.nodes[2]; pc = head.nodes[3]; pd = head.nodes[6];
            end
            default:
            begin
                pa = head.nodes[1]; pb = head.nodes[3]; pc = head.nodes[5]; pd = head.nodes[6];
            end
        endcase
    end

    // operand select for the shared multiplier
    always_comb
    begin
        case (step_reg)
            M_CX_P:  begin mul_a = u_reg.y; mul_b = diff_ext(v_reg.z); end
            M_CX_N:  begin mul_a = u_reg.z; mul_b = diff_ext(v_reg.y); end
            M_CY_P:  begin mul_a = u_reg.z; mul_b = diff_ext(v_reg.x); end
            M_CY_N:  begin mul_a = u_reg.x; mul_b = diff_ext(v_reg.z); end
            M_CZ_P:  begin mul_a = u_reg.x; mul_b = diff_ext(v_reg.y); end
            M_CZ_N:  begin mul_a = u_reg.y; mul_b = diff_ext(v_reg.x); end
            M_DOT_X: begin mul_a = w_reg.x; mul_b = cx_reg; end
            M_DOT_Y: begin mul_a = w_reg.y; mul_b = cy_reg; end
            M_DOT_Z: begin mul_a = w_reg.z; mul_b = cz_reg; end
            default: begin mul_a = '0;      mul_b = '0; end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // one divide step by six: top digit under the running remainder,
    // quotient digit by reciprocal multiply
    assign dval     = {rem_reg, div_reg[VOL_W-1 -: DIGIT_W]};
    assign rprod    = RPROD_W'(dval) * RPROD_W'(RECIP6);
    assign q_dig    = rprod[RECIP_SH +: DIGIT_W];
    assign q_six    = DVAL_W'(q_dig) * DVAL_W'(DIVISOR);
    assign rem_full = dval - q_six;

    // magnitude of the triple product sum
    assign jsum_mag = jsum_reg[VOL_W-1] ? VOL_W'(-jsum_reg) : VOL_W'(jsum_reg);

    // saturating total and range test
    assign sum_ext   = (TOTAL_W+1)'(total_reg) + (TOTAL_W+1)'(vol_reg);
    assign total_new = (sum_ext[TOTAL_W] != sum_ext[TOTAL_W-1])
                     ? (sum_ext[TOTAL_W] ? TOTAL_MIN : TOTAL_MAX)
                     : sum_ext[TOTAL_W-1:0];
    assign vol_ext   = LIM_W'(vol_reg);
    assign bad       = (vol_ext > hi_lim_reg) || (vol_ext < lo_lim_reg);

    assign out_xfer  = result_out.valid && result_out.ready;

    // sequencing counters, running total and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tet_reg       <= '0;
            step_reg      <= '0;
            div_cnt_reg   <= '0;
            prod_vld_reg  <= 1'b0;
            prod_idx_reg  <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= (state_reg == BK_MUL);
            prod_idx_reg <= step_reg;
            if (start_job)
                tet_reg <= '0;
            if (state_reg == BK_LOAD)
                step_reg <= '0;
            if (state_reg == BK_MUL)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == M_DOT_Z)
                    tet_reg <= tet_reg + 1'b1;
            end
            if (state_reg == BK_ROUND)
                div_cnt_reg <= '0;
            if (state_reg == BK_DIV)
                div_cnt_reg <= div_cnt_reg + 1'b1;
            if (clear_job)
                total_reg <= '0;
            if (emit)
            begin
                total_reg     <= total_new;
                out_valid_reg <= 1'b1;
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        // widened range limits follow the configuration
        hi_lim_reg <= LIM_W'(vmax) + $signed({3'b000, tol});
        lo_lim_reg <= LIM_W'(vmin) - $signed({3'b000, tol});

        // edge vectors of the current tetrahedron
        if (state_reg == BK_LOAD)
        begin
            u_reg <= node_diff(pb, pa);
            v_reg <= node_diff(pc, pa);
            w_reg <= node_diff(pd, pa);
        end

        if (state_reg == BK_MUL)
            prod_reg <= mul_p;

        // fold the previous product into cross terms or the sum
        if (start_job)
            jsum_reg <= '0;
        if (prod_vld_reg)
        begin
            case (prod_idx_reg)
                M_CX_P, M_CY_P, M_CZ_P:
                    hold_reg <= prod_reg[HOLD_W-1:0];
                M_CX_N:
                    cx_reg <= $signed({hold_reg[HOLD_W-1], hold_reg}) - prod_reg[CROSS_W-1:0];
                M_CY_N:
                    cy_reg <= $signed({hold_reg[HOLD_W-1], hold_reg}) - prod_reg[CROSS_W-1:0];
                M_CZ_N:
                    cz_reg <= $signed({hold_reg[HOLD_W-1], hold_reg}) - prod_reg[CROSS_W-1:0];
                M_DOT_X, M_DOT_Y, M_DOT_Z:
                    jsum_reg <= jsum_reg + VOL_W'(prod_reg);
                default:
                    hold_reg <= hold_reg;
            endcase
        end

        // round to nearest, ties away from zero, then divide the magnitude
        if (state_reg == BK_ROUND)
        begin
            neg_reg <= jsum_reg[VOL_W-1];
            div_reg <= jsum_mag + ROUND_HALF;
            rem_reg <= '0;
        end
        if (state_reg == BK_DIV)
        begin
            div_reg <= {div_reg[VOL_W-DIGIT_W-1:0], q_dig};
            rem_reg <= rem_full[REM_W-1:0];
        end
        if (state_reg == BK_SIGN)
            vol_reg <= neg_reg ? -$signed(div_reg) : $signed(div_reg);

        // result register
        if (emit)
        begin
            out_vol_reg   <= vol_reg;
            out_bad_reg   <= bad;
            out_total_reg <= total_new;
            out_id_reg    <= head.tag;
        end
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.element_volume = out_vol_reg;
    assign result_out.out_of_range   = out_bad_reg;
    assign result_out.running_total  = out_total_reg;
    assign result_out.element_id_out = out_id_reg;
endmodule

/* rtl/core/knife_element_volume_check.sv */
// Knife element volume check: one node per transfer, with diagnostics on one result per
// seven nodes. Nodes are taken one per cycle while the two-entry job queue has room.
// From the seventh node a result passes the job queue, then pick-up, four tetrahedra
// on the shared multiplier, drain, round, 4 digit steps, sign and emit, which waits
// while a result is still offered. Nodes of later elements are taken meanwhile.
// Reset: asynchronous active low; clears node count, total, queue and result valid.
module knife_element_volume_check
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    kevc_node_if.sink                            node_in,
    kevc_result_if.source                        result_out,
    input  logic                                 cfg_we,
    input  logic [kevc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [kevc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import kevc_pkg::*;

    logic                    diag_reg;
    logic signed [VOL_W-1:0] vmin_reg;
    logic signed [VOL_W-1:0] vmax_reg;
    logic [TOL_W-1:0]        tol_reg;

    logic      push;
    kevc_job_t push_job;
    logic      full;
    logic      pop;
    kevc_job_t head;
    logic      empty;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diag_reg <= 1'b1;
            vmin_reg <= '0;
            vmax_reg <= VMAX_RESET;
            tol_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (kevc_reg_t'(cfg_index))
                REG_DIAG: diag_reg <= cfg_data[0];
                REG_VMIN: vmin_reg <= $signed(cfg_data[VOL_W-1:0]);
                REG_VMAX: vmax_reg <= $signed(cfg_data[VOL_W-1:0]);
                REG_TOL:  tol_reg  <= cfg_data[TOL_W-1:0];
                default:  diag_reg <= diag_reg;
            endcase
        end
    end

    // node collection
    kevc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .node_in  (node_in),
        .diag_en  (diag_reg),
        .full     (full),
        .push     (push),
        .push_job (push_job)
    );

    // job queue
    kevc_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    // volume computation and reporting
    kevc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .vmin       (vmin_reg),
        .vmax       (vmax_reg),
        .tol        (tol_reg),
        .result_out (result_out)
    );
endmodule

/* rtl/core/kevc_checker.sv */
// port-level checks for the knife element volume check, bound to the top level
`include "knife_element_volume_check_defines.svh"

module kevc_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [kevc_pkg::VOL_W-1:0]  element_volume,
    input logic                               out_of_range,
    input logic signed [kevc_pkg::TOTAL_W-1:0] running_total,
    input logic [kevc_pkg::TAG_W-1:0]         element_id_out
);
    // a stalled result stays offered
    `KEVC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // a stalled result keeps its fields
    `KEVC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(element_volume) && $stable(out_of_range) && $stable(running_total) && $stable(element_id_out))

    // result register never reloads in the cycle it empties
    `KEVC_ASSERT_NEXT(a_out_gap, clk, rst_n, out_valid && out_ready, !out_valid)

    // no result offered while in reset
    `KEVC_ASSERT_RESET(a_rst_idle, clk, rst_n, !out_valid)
endmodule

bind knife_element_volume_check kevc_checker u_kevc_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (result_out.valid),
    .out_ready      (result_out.ready),
    .element_volume (result_out.element_volume),
    .out_of_range   (result_out.out_of_range),
    .running_total  (result_out.running_total),
    .element_id_out (result_out.element_id_out)
);
